[src/thermal_fan_level_policy_macros.svh]
// Assertion macros for the fan level policy block.
`ifndef THERMAL_FAN_LEVEL_POLICY_MACROS_SVH
`define THERMAL_FAN_LEVEL_POLICY_MACROS_SVH

// Checked on every edge once reset is released.
`define TFL_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TFL_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tfl_pkg.sv]
// Package for the fan level policy: sizes, field types and constant tables.
`timescale 1ns / 1ps

package tfl_pkg;

  localparam int NUM_SENSORS = 5;
  localparam int NUM_FANS    = 6;
  localparam int TEMP_W      = 19;
  localparam int TH_W        = 21;
  localparam int DUTY_W      = 7;
  localparam int LEVEL_W     = 2;
  localparam int CAUSE_W     = 2;

  localparam int IN_DATA_BITS  = NUM_SENSORS * TEMP_W + 2 * NUM_FANS;
  localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_DATA_BITS = DUTY_W + LEVEL_W;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_DATA_BITS;

  // tuser bit positions on the input side
  localparam int IN_USER_DIR   = 0;
  localparam int IN_USER_RDERR = 1;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [TH_W-1:0]   th_t;
  typedef logic [DUTY_W-1:0]        duty_t;
  typedef logic [LEVEL_W-1:0]       level_t;
  typedef logic [NUM_FANS-1:0]      fan_mask_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_THERMAL    = 2'd0,
    CAUSE_FAN_FAILED = 2'd1,
    CAUSE_FAN_ABSENT = 2'd2,
    CAUSE_READ_ERROR = 2'd3
  } cause_t;

  localparam level_t LEVEL_MIN = '0;
  localparam level_t LEVEL_MAX = '1;
  localparam duty_t  DUTY_FULL = duty_t'(100);
  localparam th_t    TH_NONE   = th_t'(999999);
  localparam th_t    TH_ZERO   = th_t'(0);

  // [direction][level]; direction 0 is back-to-front
  localparam duty_t DUTY_TAB [2][4] = '{
    '{duty_t'(39), duty_t'(46), duty_t'(67), DUTY_FULL},
    '{duty_t'(39), duty_t'(46), duty_t'(60), DUTY_FULL}
  };

  // [direction][level][sensor], level rises when any reading >= entry
  localparam th_t UP_TAB [2][4][NUM_SENSORS] = '{
    '{
      '{th_t'(30000), th_t'(35000), th_t'(43000), th_t'(25000), th_t'(25000)},
      '{th_t'(38000), th_t'(43000), th_t'(49000), th_t'(34000), th_t'(33000)},
      '{th_t'(50000), th_t'(53000), th_t'(58000), th_t'(47000), th_t'(46000)},
      '{TH_NONE, TH_NONE, TH_NONE, TH_NONE, TH_NONE}
    },
    '{
      '{th_t'(52000), th_t'(38000), th_t'(32000), th_t'(27000), th_t'(30000)},
      '{th_t'(60000), th_t'(45000), th_t'(41000), th_t'(33000), th_t'(36000)},
      '{th_t'(68000), th_t'(56000), th_t'(51000), th_t'(45000), th_t'(47000)},
      '{TH_NONE, TH_NONE, TH_NONE, TH_NONE, TH_NONE}
    }
  };

  // [direction][level][sensor], level falls when every reading <= entry
  localparam th_t DOWN_TAB [2][4][NUM_SENSORS] = '{
    '{
      '{TH_ZERO, TH_ZERO, TH_ZERO, TH_ZERO, TH_ZERO},
      '{th_t'(25000), th_t'(30000), th_t'(38000), th_t'(20000), th_t'(20000)},
      '{th_t'(33000), th_t'(38000), th_t'(44000), th_t'(29000), th_t'(27000)},
      '{th_t'(45000), th_t'(48000), th_t'(53000), th_t'(42000), th_t'(41000)}
    },
    '{
      '{TH_ZERO, TH_ZERO, TH_ZERO, TH_ZERO, TH_ZERO},
      '{th_t'(47000), th_t'(33000), th_t'(27000), th_t'(23000), th_t'(25000)},
      '{th_t'(55000), th_t'(40000), th_t'(36000), th_t'(28000), th_t'(31000)},
      '{th_t'(63000), th_t'(51000), th_t'(46000), th_t'(39000), th_t'(42000)}
    }
  };

  // Stored duty back to a level; anything not in the lower three rows is top.
  function automatic level_t level_of_duty(input logic dir, input duty_t duty);
    level_t lvl;
    lvl = LEVEL_MAX;
    if (duty == DUTY_TAB[dir][2]) lvl = level_t'(2);
    if (duty == DUTY_TAB[dir][1]) lvl = level_t'(1);
    if (duty == DUTY_TAB[dir][0]) lvl = level_t'(0);
    return lvl;
  endfunction

endpackage

[src/thermal_fan_level_policy.sv]
// Fan level policy: hysteresis level control over a multi-sensor snapshot.
`timescale 1ns / 1ps
`include "thermal_fan_level_policy_macros.svh"

//  channel | dir | width        | contents
//  in_     | in  | tdata 112    | five temps, failed mask, present mask
//          |     | tuser 2      | airflow direction, read error
//  out_    | out | tdata 16     | duty, level
//          |     | tuser 2      | cause
//
//  One beat per cycle while out_tready stays high; a beat goes through the
//  input register, then the result register, one table compare pass between.
//  The stored duty updates as a beat moves into the result register, so the
//  next beat in the input register always sees the previous beat's duty.
//  Reset (rst_n low, synchronous) empties both registers and sets duty to 100.
//  An output stall holds the result and fills the input register, then
//  in_tready drops until out_tready returns.

module thermal_fan_level_policy (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [18:0] temp_cpu, [37:19] temp_board1, [56:38] temp_board2,
  // [75:57] temp_board3, [94:76] temp_board4, [100:95] fan_failed_mask,
  // [106:101] fan_present_mask, [111:107] zero
  input  logic [tfl_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] airflow_front_to_back, [1] read_error
  input  logic [tfl_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [6:0] duty_percent, [8:7] level, [15:9] zero
  output logic [tfl_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] cause
  output logic [tfl_pkg::CAUSE_W-1:0]     out_tuser
);

  // input register
  logic                      s1_valid_r;
  tfl_pkg::temp_t            s1_temp_r [tfl_pkg::NUM_SENSORS];
  logic                      s1_dir_r;
  tfl_pkg::fan_mask_t        s1_failed_r;
  tfl_pkg::fan_mask_t        s1_present_r;
  logic                      s1_rderr_r;

  // result register and policy state
  logic                      out_valid_r;
  tfl_pkg::duty_t            out_duty_r;
  tfl_pkg::level_t           out_level_r;
  tfl_pkg::cause_t           out_cause_r;
  tfl_pkg::duty_t            duty_r;

  logic                      s1_adv;
  logic                      in_beat;
  tfl_pkg::cause_t           cause_nxt;
  tfl_pkg::level_t           level_cur;
  tfl_pkg::level_t           level_nxt;
  tfl_pkg::duty_t            duty_nxt;
  logic                      up_hit;
  logic                      down_all;

  // Result register frees when empty or being taken; input register frees
  // when empty or moving forward.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_beat   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      for (int i = 0; i < tfl_pkg::NUM_SENSORS; i++) begin
        s1_temp_r[i] <= in_tdata[i*tfl_pkg::TEMP_W +: tfl_pkg::TEMP_W];
      end
      s1_failed_r  <= in_tdata[tfl_pkg::NUM_SENSORS*tfl_pkg::TEMP_W +: tfl_pkg::NUM_FANS];
      s1_present_r <= in_tdata[tfl_pkg::NUM_SENSORS*tfl_pkg::TEMP_W + tfl_pkg::NUM_FANS
                               +: tfl_pkg::NUM_FANS];
      s1_dir_r     <= in_tuser[tfl_pkg::IN_USER_DIR];
      s1_rderr_r   <= in_tuser[tfl_pkg::IN_USER_RDERR];
    end
  end

  // Fault priority: read error, then failed fan, then missing fan.
  always_comb begin
    if (s1_rderr_r) begin
      cause_nxt = tfl_pkg::CAUSE_READ_ERROR;
    end else if (|s1_failed_r) begin
      cause_nxt = tfl_pkg::CAUSE_FAN_FAILED;
    end else if (s1_present_r != '1) begin
      cause_nxt = tfl_pkg::CAUSE_FAN_ABSENT;
    end else begin
      cause_nxt = tfl_pkg::CAUSE_THERMAL;
    end
  end

  // Thermal path: one parallel compare per sensor against the current row.
  always_comb begin
    level_cur = tfl_pkg::level_of_duty(s1_dir_r, duty_r);
    up_hit    = 1'b0;
    down_all  = 1'b1;
    for (int i = 0; i < tfl_pkg::NUM_SENSORS; i++) begin
      if (tfl_pkg::th_t'(s1_temp_r[i]) >= tfl_pkg::UP_TAB[s1_dir_r][level_cur][i]) begin
        up_hit = 1'b1;
      end
      if (tfl_pkg::th_t'(s1_temp_r[i]) > tfl_pkg::DOWN_TAB[s1_dir_r][level_cur][i]) begin
        down_all = 1'b0;
      end
    end

    if (cause_nxt != tfl_pkg::CAUSE_THERMAL) begin
      level_nxt = tfl_pkg::LEVEL_MAX;
      duty_nxt  = tfl_pkg::DUTY_FULL;
    end else begin
      if (up_hit) begin
        // top row never trips, saturate anyway
        level_nxt = (level_cur == tfl_pkg::LEVEL_MAX) ? level_cur : level_cur + 1'b1;
      end else if (down_all) begin
        level_nxt = (level_cur == tfl_pkg::LEVEL_MIN) ? level_cur : level_cur - 1'b1;
      end else begin
        level_nxt = level_cur;
      end
      duty_nxt = tfl_pkg::DUTY_TAB[s1_dir_r][level_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      duty_r      <= tfl_pkg::DUTY_FULL;
    end else begin
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        duty_r      <= duty_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_duty_r  <= duty_nxt;
      out_level_r <= level_nxt;
      out_cause_r <= cause_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{tfl_pkg::OUT_PAD_W{1'b0}}, out_level_r, out_duty_r};
  assign out_tuser  = out_cause_r;

  // stored duty always tracks the last result produced
  `TFL_ASSERT_RUN(a_duty_tracks_result, s1_adv |=> (duty_r == out_duty_r), "duty state out of step with result")
  // any fault forces full speed
  `TFL_ASSERT_RUN(a_fault_full, (out_valid_r && (out_cause_r != tfl_pkg::CAUSE_THERMAL)) |-> (out_duty_r == tfl_pkg::DUTY_FULL && out_level_r == tfl_pkg::LEVEL_MAX), "fault result not at full speed")
  // back-pressure only when both registers are occupied
  `TFL_ASSERT_RUN(a_ready_only_full, !in_tready |-> (s1_valid_r && out_valid_r), "input stalled with a free register")
  // reset restores full duty
  `TFL_ASSERT_ALL(a_reset_duty, !rst_n |=> (duty_r == tfl_pkg::DUTY_FULL && !out_valid_r), "reset did not restore duty")

endmodule

[verif/tb_thermal_fan_level_policy.sv]
// Self-checking testbench for the fan level policy: directed and random ticks, scoreboarded.
`timescale 1ns / 1ps

module tb_thermal_fan_level_policy;

  // Tick as the block sees it; temps[0] is the CPU reading, temps[1..4] the board sensors.
  typedef struct packed {
    logic                                                  rderr;
    tfl_pkg::fan_mask_t                                    present;
    tfl_pkg::fan_mask_t                                    failed;
    logic                                                  dir;
    logic [tfl_pkg::NUM_SENSORS-1:0][tfl_pkg::TEMP_W-1:0]  temps;
  } tick_t;

  // One fan command coming back per tick.
  typedef struct packed {
    tfl_pkg::duty_t  duty;
    tfl_pkg::level_t level;
    tfl_pkg::cause_t cause;
  } fan_cmd_t;

  localparam int              NO_LIMIT  = 999999;
  localparam int              TOP_LEVEL = 3;
  localparam tfl_pkg::duty_t  FULL_DUTY = tfl_pkg::duty_t'(100);

  // Duty per level, [airflow][level]; airflow 0 is back-to-front.
  localparam int DUTY_BY_LEVEL [2][4] = '{
    '{39, 46, 67, 100},
    '{39, 46, 60, 100}
  };

  // Level rises when any reading is at or above its entry.
  localparam int UP_LIMIT [2][4][tfl_pkg::NUM_SENSORS] = '{
    '{
      '{30000, 35000, 43000, 25000, 25000},
      '{38000, 43000, 49000, 34000, 33000},
      '{50000, 53000, 58000, 47000, 46000},
      '{NO_LIMIT, NO_LIMIT, NO_LIMIT, NO_LIMIT, NO_LIMIT}
    },
    '{
      '{52000, 38000, 32000, 27000, 30000},
      '{60000, 45000, 41000, 33000, 36000},
      '{68000, 56000, 51000, 45000, 47000},
      '{NO_LIMIT, NO_LIMIT, NO_LIMIT, NO_LIMIT, NO_LIMIT}
    }
  };

  // Level falls when every reading is at or below its entry.
  localparam int DOWN_LIMIT [2][4][tfl_pkg::NUM_SENSORS] = '{
    '{
      '{0, 0, 0, 0, 0},
      '{25000, 30000, 38000, 20000, 20000},
      '{33000, 38000, 44000, 29000, 27000},
      '{45000, 48000, 53000, 42000, 41000}
    },
    '{
      '{0, 0, 0, 0, 0},
      '{47000, 33000, 27000, 23000, 25000},
      '{55000, 40000, 36000, 28000, 31000},
      '{63000, 51000, 46000, 39000, 42000}
    }
  };

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [tfl_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [tfl_pkg::IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tfl_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [tfl_pkg::CAUSE_W-1:0]     out_tuser;

  tick_t          tick_queue [$];    // ticks waiting for the driver
  fan_cmd_t       pending_cmds [$];  // predicted commands, oldest first
  tfl_pkg::duty_t held_duty;         // predictor copy of the stored duty
  tfl_pkg::duty_t plan_duty;         // stored duty as the stimulus planner sees it
  int             mismatch_count = 0;

  thermal_fan_level_policy uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stored duty to level for one airflow; a duty missing from the lower three
  // rows (e.g. left over from the other airflow) counts as the top level.
  function automatic int duty_level(input logic dir, input tfl_pkg::duty_t duty);
    int lvl;
    lvl = TOP_LEVEL;
    for (int l = TOP_LEVEL - 1; l >= 0; l--) begin
      if (int'(duty) == DUTY_BY_LEVEL[dir][l]) lvl = l;
    end
    return lvl;
  endfunction

  // Fan command for one tick given the duty stored before it.
  function automatic fan_cmd_t next_fan_cmd(input tick_t tk, input tfl_pkg::duty_t duty_now);
    fan_cmd_t cmd;
    int       lvl;
    int       reading;
    bit       go_up;
    bit       go_down;
    // fault priority: read error, then failed fan, then absent fan
    if (tk.rderr)                cmd.cause = tfl_pkg::CAUSE_READ_ERROR;
    else if (tk.failed != '0)    cmd.cause = tfl_pkg::CAUSE_FAN_FAILED;
    else if (tk.present != '1)   cmd.cause = tfl_pkg::CAUSE_FAN_ABSENT;
    else                         cmd.cause = tfl_pkg::CAUSE_THERMAL;
    if (cmd.cause != tfl_pkg::CAUSE_THERMAL) begin
      cmd.level = tfl_pkg::level_t'(TOP_LEVEL);
      cmd.duty  = FULL_DUTY;
    end else begin
      lvl     = duty_level(tk.dir, duty_now);
      go_up   = 1'b0;
      go_down = 1'b1;
      for (int s = 0; s < tfl_pkg::NUM_SENSORS; s++) begin
        reading = $signed(tk.temps[s]);
        if (reading >= UP_LIMIT[tk.dir][lvl][s]) go_up = 1'b1;
        if (reading > DOWN_LIMIT[tk.dir][lvl][s]) go_down = 1'b0;
      end
      // up wins over down; both saturate at the ends of the range
      if (go_up) lvl = (lvl == TOP_LEVEL) ? TOP_LEVEL : lvl + 1;
      else if (go_down) lvl = (lvl == 0) ? 0 : lvl - 1;
      cmd.level = tfl_pkg::level_t'(lvl);
      cmd.duty  = tfl_pkg::duty_t'(DUTY_BY_LEVEL[tk.dir][lvl]);
    end
    return cmd;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 40) $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Queue one tick and advance the planner's view of the stored duty.
  task automatic queue_tick(input int t0, input int t1, input int t2, input int t3,
                            input int t4, input logic dir, input tfl_pkg::fan_mask_t failed,
                            input tfl_pkg::fan_mask_t present, input logic rderr);
    tick_t    tk;
    fan_cmd_t cmd;
    tk.temps[0] = tfl_pkg::TEMP_W'(t0);
    tk.temps[1] = tfl_pkg::TEMP_W'(t1);
    tk.temps[2] = tfl_pkg::TEMP_W'(t2);
    tk.temps[3] = tfl_pkg::TEMP_W'(t3);
    tk.temps[4] = tfl_pkg::TEMP_W'(t4);
    tk.dir      = dir;
    tk.failed   = failed;
    tk.present  = present;
    tk.rderr    = rderr;
    tick_queue.push_back(tk);
    cmd       = next_fan_cmd(tk, plan_duty);
    plan_duty = cmd.duty;
  endtask

  // Healthy tick with readings placed around the thresholds of the level the
  // block should be at, so rises, falls and holds all happen often.
  task automatic add_thermal_tick(input logic dir);
    int lvl;
    int kind;
    int pick;
    int lo;
    int hi;
    int t [tfl_pkg::NUM_SENSORS];
    lvl  = duty_level(dir, plan_duty);
    if ($urandom_range(4) == 0) lvl = $urandom_range(TOP_LEVEL);
    kind = $urandom_range(9);
    pick = $urandom_range(tfl_pkg::NUM_SENSORS - 1);
    for (int s = 0; s < tfl_pkg::NUM_SENSORS; s++) begin
      lo = DOWN_LIMIT[dir][lvl][s] + 1;
      hi = (lvl == TOP_LEVEL) ? 200000 : UP_LIMIT[dir][lvl][s] - 1;
      case (kind)
        0, 1, 2, 3, 4: begin
          // at or just below the down threshold
          t[s] = DOWN_LIMIT[dir][lvl][s] - (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4000));
        end
        5, 6: begin
          t[s] = lo + $urandom_range(hi - lo);
        end
        7: begin
          t[s] = $urandom_range(300000) - 100000;
        end
        default: begin
          // anywhere in the 19-bit code space
          t[s] = $signed(tfl_pkg::TEMP_W'($urandom));
        end
      endcase
    end
    // one reading just over the down threshold blocks the fall
    if (kind == 1 && $urandom_range(1) == 1) t[pick] = DOWN_LIMIT[dir][lvl][pick] + 1;
    // one reading on the up threshold, or one below it
    if (kind >= 2 && kind <= 4) begin
      if (lvl == TOP_LEVEL) t[pick] = $urandom_range(200000, 40000);
      else t[pick] = UP_LIMIT[dir][lvl][pick] - $urandom_range(1);
    end
    queue_tick(t[0], t[1], t[2], t[3], t[4], dir, '0, '1, 1'b0);
  endtask

  // Driver: pops the next tick once the bus is free, then idles for a drawn
  // number of cycles after that beat is taken. Bursts with no idling come in
  // stretches. Prediction runs on the beat that was accepted at this edge.
  tick_t    drv_tick;
  fan_cmd_t accepted_cmd;
  int       gap_left;
  bit       gap_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  = 0;
      held_duty = FULL_DUTY;
    end else begin
      if (in_tvalid && in_tready) begin
        accepted_cmd = next_fan_cmd(drv_tick, held_duty);
        held_duty    = accepted_cmd.duty;
        pending_cmds.push_back(accepted_cmd);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          drv_tick  = tick_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= tfl_pkg::IN_TDATA_W'({drv_tick.present, drv_tick.failed,
                                             drv_tick.temps});
          in_tuser  <= {drv_tick.rderr, drv_tick.dir};
          if ($urandom_range(59) == 0) gap_burst = !gap_burst;
          gap_left = gap_burst ? 0 : $urandom_range(6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat against the oldest prediction,
  // then holds tready low for a drawn stall before the next one.
  fan_cmd_t want_cmd;
  int       stall_left;
  bit       stall_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_cmds.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected: tdata %h tuser %h",
                                  out_tdata, out_tuser));
        end else begin
          want_cmd = pending_cmds.pop_front();
          if (out_tdata[tfl_pkg::DUTY_W-1:0] !== want_cmd.duty)
            flag_mismatch($sformatf("duty %0d, expected %0d",
                                    out_tdata[tfl_pkg::DUTY_W-1:0], want_cmd.duty));
          if (out_tdata[tfl_pkg::DUTY_W +: tfl_pkg::LEVEL_W] !== want_cmd.level)
            flag_mismatch($sformatf("level %0d, expected %0d",
                                    out_tdata[tfl_pkg::DUTY_W +: tfl_pkg::LEVEL_W],
                                    want_cmd.level));
          if (out_tuser !== want_cmd.cause)
            flag_mismatch($sformatf("cause %0d, expected %0d", out_tuser, want_cmd.cause));
          if (out_tdata[tfl_pkg::OUT_TDATA_W-1:tfl_pkg::OUT_DATA_BITS] !== '0)
            flag_mismatch($sformatf("tdata pad bits %h not zero",
                                    out_tdata[tfl_pkg::OUT_TDATA_W-1:tfl_pkg::OUT_DATA_BITS]));
        end
        if ($urandom_range(59) == 0) stall_burst = !stall_burst;
        stall_left = stall_burst ? 0 : $urandom_range(6);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  logic rand_dir;

  initial begin
    plan_duty = FULL_DUTY;

    // Directed: walk down from the reset duty, then past the bottom level.
    queue_tick(0, 0, 0, 0, 0, 1'b0, '0, '1, 1'b0);
    queue_tick(0, 0, 0, 0, 0, 1'b0, '0, '1, 1'b0);
    queue_tick(0, 0, 0, 0, 0, 1'b0, '0, '1, 1'b0);
    queue_tick(0, 0, 0, 0, 0, 1'b0, '0, '1, 1'b0);
    // CPU exactly on its level 0 up threshold
    queue_tick(30000, 0, 0, 0, 0, 1'b0, '0, '1, 1'b0);
    // one below the up threshold, above the down one: hold
    queue_tick(37999, 0, 0, 0, 0, 1'b0, '0, '1, 1'b0);
    // last board sensor on its level 1 up threshold
    queue_tick(0, 0, 0, 0, 33000, 1'b0, '0, '1, 1'b0);
    queue_tick(200000, 200000, 200000, 200000, 200000, 1'b0, '0, '1, 1'b0);
    // top level cannot rise, even at the largest code
    queue_tick(262143, 262143, 262143, 262143, 262143, 1'b0, '0, '1, 1'b0);
    queue_tick(-100000, -100000, -100000, -100000, -100000, 1'b0, '0, '1, 1'b0);
    // airflow flip leaves 67 unmapped: treated as top level, falls to 60
    queue_tick(0, 0, 0, 0, 0, 1'b1, '0, '1, 1'b0);
    // and back: 60 is unmapped back-to-front too
    queue_tick(0, 0, 0, 0, 0, 1'b0, '0, '1, 1'b0);
    queue_tick(-262144, -262144, -262144, -262144, -262144, 1'b0, '0, '1, 1'b0);
    // faults, alone and stacked
    queue_tick(0, 0, 0, 0, 0, 1'b0, '0, '1, 1'b1);
    queue_tick(0, 0, 0, 0, 0, 1'b0, 6'h01, '1, 1'b0);
    queue_tick(0, 0, 0, 0, 0, 1'b1, 6'h20, '1, 1'b0);
    queue_tick(0, 0, 0, 0, 0, 1'b0, '0, 6'h3e, 1'b0);
    queue_tick(0, 0, 0, 0, 0, 1'b1, '0, 6'h1f, 1'b0);
    queue_tick(0, 0, 0, 0, 0, 1'b0, '1, '0, 1'b1);
    queue_tick(0, 0, 0, 0, 0, 1'b0, '1, '0, 1'b0);
    queue_tick(0, 0, 0, 0, 0, 1'b1, '0, '0, 1'b0);
    // front-to-back from full duty, then board1 on its level 2 up threshold
    queue_tick(0, 0, 0, 0, 0, 1'b1, '0, '1, 1'b0);
    queue_tick(0, 56000, 0, 0, 0, 1'b1, '0, '1, 1'b0);

    // Random: mostly healthy threshold-hugging ticks, some fault noise and
    // occasional airflow flips that hit the unmapped-duty path.
    rand_dir = 1'b0;
    repeat (1800) begin
      if ($urandom_range(24) == 0) rand_dir = ~rand_dir;
      if ($urandom_range(11) == 0)
        queue_tick($urandom_range(300000) - 100000, $urandom_range(300000) - 100000,
                   $urandom_range(300000) - 100000, $signed(tfl_pkg::TEMP_W'($urandom)),
                   $signed(tfl_pkg::TEMP_W'($urandom)), rand_dir,
                   ($urandom_range(1) == 1) ? tfl_pkg::fan_mask_t'($urandom)
                                            : tfl_pkg::fan_mask_t'(0),
                   ($urandom_range(1) == 1) ? tfl_pkg::fan_mask_t'($urandom)
                                            : tfl_pkg::fan_mask_t'('1),
                   ($urandom_range(2) == 0));
      else
        add_thermal_tick(rand_dir);
    end

    // reset held low from time zero, then released once
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (tick_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    // two-stage pipe: the closing wait catches any stray beat
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("thermal_fan_level_policy test passed");
    end else begin
      $display("thermal_fan_level_policy test failed");
    end
    $finish;
  end

  // Slowest run is 1823 beats; this timeout is several times the longest it can take.
  initial begin
    #2000000;
    $display("thermal_fan_level_policy test failed");
    $finish;
  end

endmodule
